@@ rtl/rmb_pkg.sv @@
// Shared types, constants and helper functions for the rotation matrix builder.
// No dependencies; every other file imports this package.
`default_nettype none
package rmb_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  // CORDIC start value: the inverse gain in Q3.30.
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  // One in Q1.14.
  localparam logic signed [15:0] ONE_Q14  = 16'sd16384;

  typedef enum logic [1:0] {
    CMD_AXIS_ANGLE = 2'd0,
    CMD_EULER_XYZ  = 2'd1,
    CMD_EULER_YXZ  = 2'd2,
    CMD_ZERO       = 2'd3
  } cmd_e;

  // Arctangent of 2^-i, a full turn is 2^32.
  function automatic logic signed [31:0] atan_f(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sh20000000;
      5'd1:  v = 32'sh12E4051D;
      5'd2:  v = 32'sh09FB385B;
      5'd3:  v = 32'sh051111D4;
      5'd4:  v = 32'sh028B0D43;
      5'd5:  v = 32'sh0145D7E1;
      5'd6:  v = 32'sh00A2F61E;
      5'd7:  v = 32'sh00517C55;
      5'd8:  v = 32'sh0028BE53;
      5'd9:  v = 32'sh00145F2E;
      5'd10: v = 32'sh000A2F98;
      5'd11: v = 32'sh000517CC;
      5'd12: v = 32'sh00028BE6;
      5'd13: v = 32'sh000145F3;
      5'd14: v = 32'sh0000A2F9;
      5'd15: v = 32'sh0000517C;
      5'd16: v = 32'sh000028BE;
      5'd17: v = 32'sh0000145F;
      5'd18: v = 32'sh00000A2F;
      5'd19: v = 32'sh00000517;
      5'd20: v = 32'sh0000028B;
      5'd21: v = 32'sh00000145;
      5'd22: v = 32'sh000000A2;
      5'd23: v = 32'sh00000051;
      default: v = 32'sh00000000;
    endcase
    return v;
  endfunction

  // Signed 16 x 16 product, kept at 34 bits.
  function automatic logic signed [33:0] mul16(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    logic signed [33:0] p;
    p = 34'(a) * 34'(b);
    return p;
  endfunction

  // Signed 34 x 18 product, kept at 52 bits.
  function automatic logic signed [51:0] mul34(input logic signed [33:0] a,
                                               input logic signed [17:0] b);
    logic signed [51:0] p;
    p = 52'(a) * 52'(b);
    return p;
  endfunction

endpackage
`default_nettype wire

@@ rtl/rotation_matrix_builder.sv @@
// Top level of the rotation matrix builder: three CORDIC lanes, a delay line
// for command and axis, and the matrix assembly. Depends on rmb_pkg.
//
// Usage:
//   A transaction enters when start_i is high and busy_o is low. busy_o is
//   always low: the block takes a new request in every clock cycle.
//   command_i selects axis-angle, Euler X-Y-Z or Euler Y-X-Z; command three
//   gives the all-zero matrix. Angles are binary angles, a full turn 65536.
//   Each transaction gives one result: r00_o .. r22_o, shown for exactly one
//   cycle with valid_o high. The receiver cannot stall the block.
//   Pipeline (stage count capped at 24): a register for quadrant reduction,
//   one register per CORDIC stage, one of rounding, then pair products,
//   triple products with sums, and rounding with saturation.
//   Throughput: one transaction per cycle, set by the fully pipelined CORDIC
//   lanes and multiplier stages.
//   Reset clears every valid bit at once; no result appears until new
//   transactions have passed through the pipeline.
`default_nettype none
module rotation_matrix_builder
  import rmb_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         command_i,
  input  wire logic [15:0]        angle_a_i,
  input  wire logic [15:0]        angle_b_i,
  input  wire logic [15:0]        angle_c_i,
  input  wire logic signed [15:0] axis_x_i,
  input  wire logic signed [15:0] axis_y_i,
  input  wire logic signed [15:0] axis_z_i,
  output logic                    valid_o,
  output logic signed [15:0]      r00_o,
  output logic signed [15:0]      r01_o,
  output logic signed [15:0]      r02_o,
  output logic signed [15:0]      r10_o,
  output logic signed [15:0]      r11_o,
  output logic signed [15:0]      r12_o,
  output logic signed [15:0]      r20_o,
  output logic signed [15:0]      r21_o,
  output logic signed [15:0]      r22_o
);

  localparam int NSTG  = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int LAT_C = NSTG + 2;
  localparam int LAT   = LAT_C + 3;

  logic signed [15:0] sin_w [3];
  logic signed [15:0] cos_w [3];
  logic [15:0]        ang_w [3];
  logic signed [15:0] r_w [9];

  logic               v_q   [LAT_C];
  logic [1:0]         cmd_q [LAT_C];
  logic signed [15:0] ax_q  [LAT_C];
  logic signed [15:0] ay_q  [LAT_C];
  logic signed [15:0] az_q  [LAT_C];

  assign busy_o = 1'b0;
  assign ang_w[0] = angle_a_i;
  assign ang_w[1] = angle_b_i;
  assign ang_w[2] = angle_c_i;

  // Sine and cosine lanes, one per angle.
  for (genvar l = 0; l < 3; l++) begin : g_lane
    rmb_cordic #(.NSTG(NSTG)) u_cordic (
      .clk_i   (clk_i),
      .angle_i (ang_w[l]),
      .sin_o   (sin_w[l]),
      .cos_o   (cos_w[l])
    );
  end

  // Command and axis travel beside the CORDIC lanes.
  always_ff @(posedge clk_i) begin
    cmd_q[0] <= command_i;
    ax_q[0]  <= axis_x_i;
    ay_q[0]  <= axis_y_i;
    az_q[0]  <= axis_z_i;
    for (int k = 1; k < LAT_C; k++) begin
      cmd_q[k] <= cmd_q[k-1];
      ax_q[k]  <= ax_q[k-1];
      ay_q[k]  <= ay_q[k-1];
      az_q[k]  <= az_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT_C; k++) v_q[k] <= 1'b0;
    end else begin
      v_q[0] <= start_i && !busy_o;
      for (int k = 1; k < LAT_C; k++) v_q[k] <= v_q[k-1];
    end
  end

  // Matrix assembly and output registers.
  rmb_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_q[LAT_C-1]),
    .cmd_i   (cmd_q[LAT_C-1]),
    .ax_i    (ax_q[LAT_C-1]),
    .ay_i    (ay_q[LAT_C-1]),
    .az_i    (az_q[LAT_C-1]),
    .sin_i   (sin_w),
    .cos_i   (cos_w),
    .valid_o (valid_o),
    .r_o     (r_w)
  );

  assign r00_o = r_w[0];
  assign r01_o = r_w[1];
  assign r02_o = r_w[2];
  assign r10_o = r_w[3];
  assign r11_o = r_w[4];
  assign r12_o = r_w[5];
  assign r20_o = r_w[6];
  assign r21_o = r_w[7];
  assign r22_o = r_w[8];

`ifndef SYNTHESIS
  // Every accepted transaction gives exactly one result after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == $past(start_i && rst_ni, LAT))
    else $error("result strobe does not match accepted transaction");

  // The unused command gives an all-zero matrix; r00, r11, r22 and r12 are checked.
  a_zero_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(command_i == CMD_ZERO, LAT)) |->
      (r00_o == 16'sd0 && r11_o == 16'sd0 && r22_o == 16'sd0 && r12_o == 16'sd0))
    else $error("zero command gave a nonzero matrix");
`endif

endmodule
`default_nettype wire

@@ rtl/rmb_cordic.sv @@
// One sine/cosine lane: quadrant reduction, pipelined rotation-mode CORDIC and
// rounding with quadrant restore. Depends on rmb_pkg.
`default_nettype none
module rmb_cordic
  import rmb_pkg::*;
#(
  parameter int NSTG = CORDIC_STAGES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic [15:0]        angle_i,
  output logic signed [15:0]      sin_o,
  output logic signed [15:0]      cos_o
);

  logic signed [33:0] x_q [NSTG+1];
  logic signed [33:0] y_q [NSTG+1];
  logic signed [31:0] z_q [NSTG+1];
  logic [1:0]         q_q [NSTG+1];

  logic [15:0] sum_d;
  logic [1:0]  quad_d;
  logic [15:0] res_d;

  // Quadrant reduction: residual angle lies in a quarter turn around zero.
  always_comb begin
    sum_d  = angle_i + 16'd8192;
    quad_d = sum_d[15:14];
    res_d  = angle_i - {quad_d, 14'd0};
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= GAIN_Q30;
    y_q[0] <= '0;
    z_q[0] <= {res_d, 16'd0};
    q_q[0] <= quad_d;
  end

  // One micro-rotation per register stage.
  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (!z_q[i][31]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - atan_f(5'(i));
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + atan_f(5'(i));
      end
      q_q[i+1] <= q_q[i];
    end
  end

  logic signed [33:0] xr, yr;
  logic signed [17:0] xs, ys;
  logic signed [15:0] c_d, s_d, cq_d, sq_d;

  // Round to Q1.14, clamp to plus or minus one, then restore the quadrant.
  always_comb begin
    xr = x_q[NSTG] + 34'sd32768;
    yr = y_q[NSTG] + 34'sd32768;
    xs = 18'(xr >>> 16);
    ys = 18'(yr >>> 16);
    if (xs > 18'sd16384)       c_d = ONE_Q14;
    else if (xs < -18'sd16384) c_d = -ONE_Q14;
    else                       c_d = 16'(xs);
    if (ys > 18'sd16384)       s_d = ONE_Q14;
    else if (ys < -18'sd16384) s_d = -ONE_Q14;
    else                       s_d = 16'(ys);
    case (q_q[NSTG])
      2'd1:    begin cq_d = -s_d; sq_d = c_d;  end
      2'd2:    begin cq_d = -c_d; sq_d = -s_d; end
      2'd3:    begin cq_d = s_d;  sq_d = -c_d; end
      default: begin cq_d = c_d;  sq_d = s_d;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cos_o <= cq_d;
    sin_o <= sq_d;
  end

endmodule
`default_nettype wire

@@ rtl/rmb_matrix.sv @@
// Matrix assembly: operand selection and pair products, triple products and
// sums, then rounding and saturation to Q1.14. Depends on rmb_pkg.
`default_nettype none
module rmb_matrix
  import rmb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic [1:0]         cmd_i,
  input  wire logic signed [15:0] ax_i,
  input  wire logic signed [15:0] ay_i,
  input  wire logic signed [15:0] az_i,
  input  wire logic signed [15:0] sin_i [3],
  input  wire logic signed [15:0] cos_i [3],
  output logic                    valid_o,
  output logic signed [15:0]      r_o [9]
);

  logic signed [33:0] pa_d [9], pb_d [9], pa_q [9], pb_q [9];
  logic signed [17:0] fa_d [9], fb_d [9], fa_q [9], fb_q [9];
  logic signed [52:0] sum_d [9], sum_q [9];
  logic signed [15:0] r_d [9];
  logic               v1_q, v2_q;

  logic signed [15:0] sa, ca, sb, cb, sc, cc;
  logic signed [17:0] kf, omc;

  // Pair products and third factors per entry; entry = pa*fa + pb*fb.
  always_comb begin
    sa  = sin_i[0]; ca = cos_i[0];
    sb  = sin_i[1]; cb = cos_i[1];
    sc  = sin_i[2]; cc = cos_i[2];
    kf  = 18'(ONE_Q14);
    omc = kf - 18'(ca);
    for (int k = 0; k < 9; k++) begin
      pa_d[k] = '0; pb_d[k] = '0; fa_d[k] = '0; fb_d[k] = '0;
    end
    case (cmd_e'(cmd_i))
      CMD_AXIS_ANGLE: begin
        for (int k = 0; k < 9; k++) begin
          fa_d[k] = omc;
          fb_d[k] = kf;
        end
        pa_d[0] = mul16(ax_i, ax_i);  pb_d[0] = mul16(ca, ONE_Q14);
        pa_d[1] = mul16(ax_i, ay_i);  pb_d[1] = -mul16(az_i, sa);
        pa_d[2] = mul16(ax_i, az_i);  pb_d[2] = mul16(ay_i, sa);
        pa_d[3] = mul16(ax_i, ay_i);  pb_d[3] = mul16(az_i, sa);
        pa_d[4] = mul16(ay_i, ay_i);  pb_d[4] = mul16(ca, ONE_Q14);
        pa_d[5] = mul16(ay_i, az_i);  pb_d[5] = -mul16(ax_i, sa);
        pa_d[6] = mul16(ax_i, az_i);  pb_d[6] = -mul16(ay_i, sa);
        pa_d[7] = mul16(ay_i, az_i);  pb_d[7] = mul16(ax_i, sa);
        pa_d[8] = mul16(az_i, az_i);  pb_d[8] = mul16(ca, ONE_Q14);
      end
      CMD_EULER_XYZ: begin
        pa_d[0] = mul16(cb, cc);       fa_d[0] = kf;
        pa_d[1] = -mul16(cb, sc);      fa_d[1] = kf;
        pa_d[2] = mul16(sb, ONE_Q14);  fa_d[2] = kf;
        pa_d[3] = mul16(sa, sb);       fa_d[3] = 18'(cc);
        pb_d[3] = mul16(ca, sc);       fb_d[3] = kf;
        pa_d[4] = -mul16(sa, sb);      fa_d[4] = 18'(sc);
        pb_d[4] = mul16(ca, cc);       fb_d[4] = kf;
        pa_d[5] = -mul16(sa, cb);      fa_d[5] = kf;
        pa_d[6] = -mul16(ca, sb);      fa_d[6] = 18'(cc);
        pb_d[6] = mul16(sa, sc);       fb_d[6] = kf;
        pa_d[7] = mul16(ca, sb);       fa_d[7] = 18'(sc);
        pb_d[7] = mul16(sa, cc);       fb_d[7] = kf;
        pa_d[8] = mul16(ca, cb);       fa_d[8] = kf;
      end
      CMD_EULER_YXZ: begin
        pa_d[0] = mul16(cb, cc);       fa_d[0] = kf;
        pb_d[0] = mul16(sb, sa);       fb_d[0] = 18'(sc);
        pa_d[1] = -mul16(cb, sc);      fa_d[1] = kf;
        pb_d[1] = mul16(sb, sa);       fb_d[1] = 18'(cc);
        pa_d[2] = mul16(sb, ca);       fa_d[2] = kf;
        pa_d[3] = mul16(ca, sc);       fa_d[3] = kf;
        pa_d[4] = mul16(ca, cc);       fa_d[4] = kf;
        pa_d[5] = -mul16(sa, ONE_Q14); fa_d[5] = kf;
        pa_d[6] = -mul16(sb, cc);      fa_d[6] = kf;
        pb_d[6] = mul16(cb, sa);       fb_d[6] = 18'(sc);
        pa_d[7] = mul16(sb, sc);       fa_d[7] = kf;
        pb_d[7] = mul16(cb, sa);       fb_d[7] = 18'(cc);
        pa_d[8] = mul16(cb, ca);       fa_d[8] = kf;
      end
      default: begin
      end
    endcase
  end

  // Triple products and the sum of the two terms, in Q42.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      sum_d[k] = 53'(mul34(pa_q[k], fa_q[k])) + 53'(mul34(pb_q[k], fb_q[k]));
    end
  end

  // Round to Q1.14 and saturate to 16 bits.
  always_comb begin
    logic signed [52:0] t;
    logic signed [24:0] sh;
    for (int k = 0; k < 9; k++) begin
      t  = sum_q[k] + 53'sd134217728;
      sh = 25'(t >>> 28);
      if (sh > 25'sd32767)       r_d[k] = 16'sh7FFF;
      else if (sh < -25'sd32768) r_d[k] = 16'sh8000;
      else                       r_d[k] = 16'(sh);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pa_q  <= pa_d;
    pb_q  <= pb_d;
    fa_q  <= fa_d;
    fb_q  <= fb_d;
    sum_q <= sum_d;
    r_o   <= r_d;
  end

  // Valid bits follow the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      valid_o <= v2_q;
    end
  end

endmodule
`default_nettype wire

@@ sim/tb_rotation_matrix_builder.sv @@
// Self-checking testbench for rotation_matrix_builder: axis-angle and Euler requests
// are checked against a bit-exact matrix predictor. Depends on rmb_pkg and the RTL top.
`default_nettype none
module tb_rotation_matrix_builder;
  import rmb_pkg::*;

  localparam int   STAGES      = 16;
  localparam int   LATENCY     = STAGES + 5;
  localparam int   CYCLE_LIMIT = 200000;
  localparam longint ONE       = 16384;

  // Nine matrix entries, row by row, entry 0 is r00.
  typedef logic [8:0][15:0] matrix_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  command_i = '0;
  logic [15:0] angle_a_i = '0, angle_b_i = '0, angle_c_i = '0;
  logic signed [15:0] axis_x_i = '0, axis_y_i = '0, axis_z_i = '0;
  logic        valid_o;
  logic signed [15:0] r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;

  matrix_t expected_mats[$];
  int      error_count = 0;
  int      cycle_count = 0;

  // Entry names for mismatch reports.
  string   entry_names [9] = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21",
                               "r22"};

  longint arctan_units [24] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
    64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
  };

  rotation_matrix_builder dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i, .angle_a_i, .angle_b_i, .angle_c_i,
    .axis_x_i, .axis_y_i, .axis_z_i, .valid_o, .r00_o, .r01_o, .r02_o, .r10_o, .r11_o,
    .r12_o, .r20_o, .r21_o, .r22_o
  );

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Sine and cosine of a binary angle: quadrant fold, CORDIC, rounding to Q1.14.
  function automatic void sine_cosine(input logic [15:0] ang, output longint s,
                                      output longint c);
    longint a, q, r, x, y, z, dx, dy, t;
    a = ang;
    q = ((a + 8192) >> 14) & 3;
    r = (a - q * 16384) & 65535;
    if (r >= 32768) r -= 65536;
    z = r * 65536;
    x = 652032874;
    y = 0;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_units[i];
      end else begin
        x += dx; y -= dy; z += arctan_units[i];
      end
    end
    c = clamp((x + 32768) >>> 16, -ONE, ONE);
    s = clamp((y + 32768) >>> 16, -ONE, ONE);
    if (q == 1) begin
      t = c; c = -s; s = t;
    end else if (q == 2) begin
      c = -c; s = -s;
    end else if (q == 3) begin
      t = c; c = s; s = -t;
    end
  endfunction

  // Expected matrix for one request; every term is formed in Q42.
  function automatic matrix_t rotation_matrix(input cmd_e cmd, input logic [15:0] a,
      input logic [15:0] b, input logic [15:0] c, input logic signed [15:0] ax,
      input logic signed [15:0] ay, input logic signed [15:0] az);
    longint m [9];
    longint s1, c1, s2, c2, s3, c3, omc, x, y, z, k2;
    matrix_t res;
    k2 = ONE * ONE;
    x = ax; y = ay; z = az;
    sine_cosine(a, s1, c1);
    sine_cosine(b, s2, c2);
    sine_cosine(c, s3, c3);
    case (cmd)
      CMD_AXIS_ANGLE: begin
        omc = ONE - c1;
        m[0] = x * x * omc + c1 * k2;
        m[1] = x * y * omc - z * s1 * ONE;
        m[2] = x * z * omc + y * s1 * ONE;
        m[3] = x * y * omc + z * s1 * ONE;
        m[4] = y * y * omc + c1 * k2;
        m[5] = y * z * omc - x * s1 * ONE;
        m[6] = x * z * omc - y * s1 * ONE;
        m[7] = y * z * omc + x * s1 * ONE;
        m[8] = z * z * omc + c1 * k2;
      end
      CMD_EULER_XYZ: begin
        m[0] = c2 * c3 * ONE;
        m[1] = -c2 * s3 * ONE;
        m[2] = s2 * k2;
        m[3] = s1 * s2 * c3 + c1 * s3 * ONE;
        m[4] = -s1 * s2 * s3 + c1 * c3 * ONE;
        m[5] = -s1 * c2 * ONE;
        m[6] = -c1 * s2 * c3 + s1 * s3 * ONE;
        m[7] = c1 * s2 * s3 + s1 * c3 * ONE;
        m[8] = c1 * c2 * ONE;
      end
      CMD_EULER_YXZ: begin
        m[0] = c2 * c3 * ONE + s2 * s1 * s3;
        m[1] = -c2 * s3 * ONE + s2 * s1 * c3;
        m[2] = s2 * c1 * ONE;
        m[3] = c1 * s3 * ONE;
        m[4] = c1 * c3 * ONE;
        m[5] = -s1 * k2;
        m[6] = -s2 * c3 * ONE + c2 * s1 * s3;
        m[7] = s2 * s3 * ONE + c2 * s1 * c3;
        m[8] = c2 * c1 * ONE;
      end
      default: begin
        for (int i = 0; i < 9; i++) m[i] = 0;
      end
    endcase
    for (int i = 0; i < 9; i++)
      res[i] = 16'(clamp((m[i] + (64'sd1 <<< 27)) >>> 28, -32768, 32767));
    return res;
  endfunction

  // Send one request; start stays high so back-to-back transactions need no toggle.
  task automatic send_request(input cmd_e cmd, input logic [15:0] a, input logic [15:0] b,
      input logic [15:0] c, input logic signed [15:0] ax, input logic signed [15:0] ay,
      input logic signed [15:0] az);
    start_i   <= 1'b1;
    command_i <= cmd;
    angle_a_i <= a;
    angle_b_i <= b;
    angle_c_i <= c;
    axis_x_i  <= ax;
    axis_y_i  <= ay;
    axis_z_i  <= az;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_mats.push_back(rotation_matrix(cmd, a, b, c, ax, ay, az));
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_until_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_mats.size() != 0) @(posedge clk_i);
  endtask

  // Quadrant boundaries and extremes of every angle field.
  task automatic test_angle_extremes();
    logic [15:0] angs [8] = '{16'd0, 16'd8191, 16'd8192, 16'd16384, 16'd32768,
                              16'd40960, 16'd49152, 16'd65535};
    for (int i = 0; i < 8; i++)
      send_request(CMD_EULER_XYZ, angs[i], angs[7 - i], angs[(i + 3) % 8], 0, 0, 0);
    send_request(CMD_EULER_YXZ, 16'd8192, 16'd65535, 16'd16384, 0, 0, 0);
    send_request(CMD_EULER_YXZ, 16'd0, 16'd32768, 16'd57344, 0, 0, 0);
  endtask

  // Unit axes, non-unit and out-of-range axes that saturate.
  task automatic test_axis_extremes();
    send_request(CMD_AXIS_ANGLE, 16'd16384, 0, 0, 16'sd16384, 0, 0);
    send_request(CMD_AXIS_ANGLE, 16'd8000, 0, 0, 0, -16'sd16384, 0);
    send_request(CMD_AXIS_ANGLE, 16'd32768, 0, 0, 0, 0, 16'sd16384);
    send_request(CMD_AXIS_ANGLE, 16'd49152, 0, 0, 16'sd32767, 16'sd32767, 16'sd32767);
    send_request(CMD_AXIS_ANGLE, 16'd12345, 0, 0, -16'sd32768, -16'sd32768, 16'sd32767);
    send_request(CMD_AXIS_ANGLE, 16'd65535, 0, 0, 16'sd9459, -16'sd9459, 16'sd9459);
  endtask

  // Fields unused by a command are ignored; command three gives zeros.
  task automatic test_unused_fields_and_zero();
    send_request(CMD_AXIS_ANGLE, 16'd4000, 16'hFFFF, 16'hFFFF, 0, 16'sd16384, 0);
    send_request(CMD_EULER_XYZ, 16'd4000, 16'd5000, 16'd6000, -16'sd32768, 16'sd32767,
                 -16'sd1);
    send_request(CMD_ZERO, 16'hFFFF, 16'hFFFF, 16'hFFFF, -16'sd1, -16'sd1, -16'sd1);
    send_request(CMD_ZERO, 0, 0, 0, 0, 0, 0);
  endtask

  // Random requests in bursts with random gaps.
  task automatic test_random_traffic(input int count);
    int   sent, burst;
    cmd_e cmd;
    logic signed [15:0] ax, ay, az;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < count; i++) begin
        cmd = ($urandom_range(0, 19) == 0) ? CMD_ZERO : cmd_e'($urandom_range(0, 2));
        if ($urandom_range(0, 4) == 0) begin
          ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
        end else begin
          ax = 16'($urandom_range(0, 32768) - 16384);
          ay = 16'($urandom_range(0, 32768) - 16384);
          az = 16'($urandom_range(0, 32768) - 16384);
        end
        send_request(cmd, 16'($urandom), 16'($urandom), 16'($urandom), ax, ay, az);
        sent++;
      end
      idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
      if (sent == count / 2) wait_until_drained();
    end
  endtask

  // Result checker: each strobed matrix is compared with the oldest expectation.
  always @(posedge clk_i) begin
    matrix_t got, want;
    if (rst_ni && valid_o) begin
      got = {r22_o, r21_o, r20_o, r12_o, r11_o, r10_o, r02_o, r01_o, r00_o};
      if (expected_mats.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        error_count++;
      end else begin
        want = expected_mats.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== want[i]) begin
            $display("%0t: %s expected %0d actual %0d", $time, entry_names[i],
                     $signed(want[i]), $signed(got[i]));
            error_count++;
          end
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_angle_extremes();
    test_axis_extremes();
    idle_cycles(3);
    test_unused_fields_and_zero();
    wait_until_drained();
    test_random_traffic(900);
    wait_until_drained();
    repeat (LATENCY + 5) @(posedge clk_i);
    if (error_count == 0 && expected_mats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
